// ===== src/oas_pkg.sv =====
// ----------------------------------------------------------------------------
// oas_pkg
// Shared types and constants of the obstacle avoidance sequencer.
// ----------------------------------------------------------------------------
package oas_pkg;

  // sequence phases
  typedef enum logic [3:0] {
    PH_CRUISE         = 4'd0,
    PH_STOP           = 4'd1,
    PH_BACKUP         = 4'd2,
    PH_PAUSE          = 4'd3,
    PH_SCAN_LEFT      = 4'd4,
    PH_SCAN_CENTRE    = 4'd5,
    PH_SCAN_RIGHT     = 4'd6,
    PH_TURN           = 4'd7,
    PH_BLOCKED_BACKUP = 4'd8,
    PH_BLOCKED_TURN   = 4'd9,
    PH_FINAL_PAUSE    = 4'd10
  } phase_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ECHO_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BACKUP_TICKS   = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TURN_TICKS     = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKED_EXTRA  = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_TICKS     = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAUSE_TICKS    = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_TICKS   = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_CRUISE_SPEED   = 4'd7;

  // motor speeds
  localparam logic [7:0] SPEED_MAX  = 8'd150;
  localparam logic [7:0] BACK_SPEED = 8'd80;
  localparam logic [7:0] TURN_FAST  = 8'd150;
  localparam logic [7:0] TURN_SLOW  = 8'd50;

  // servo positions
  localparam logic [1:0] SERVO_POS_LEFT  = 2'd0;
  localparam logic [1:0] SERVO_CENTRE    = 2'd1;
  localparam logic [1:0] SERVO_POS_RIGHT = 2'd2;

  localparam int unsigned TICK_BITS = 9;

  typedef struct packed {
    logic [15:0] echo_threshold_us;
    logic [7:0]  backup_ticks;
    logic [7:0]  turn_ticks;
    logic [7:0]  blocked_extra_ticks;
    logic [7:0]  stop_ticks;
    logic [7:0]  pause_ticks;
    logic [7:0]  settle_ticks;
    logic [7:0]  cruise_speed;
  } cfg_t;

  typedef struct packed {
    logic       left_reverse;
    logic [7:0] left_speed;
    logic       right_reverse;
    logic [7:0] right_speed;
    logic [1:0] servo_position;
    logic [3:0] phase_now;
  } result_t;

endpackage

// ===== src/oas_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// oas_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module oas_cfg_regs
  import oas_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data,
  output cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_threshold_us   <= 16'd1177;
      cfg.backup_ticks        <= 8'd8;
      cfg.turn_ticks          <= 8'd6;
      cfg.blocked_extra_ticks <= 8'd3;
      cfg.stop_ticks          <= 8'd3;
      cfg.pause_ticks         <= 8'd2;
      cfg.settle_ticks        <= 8'd4;
      cfg.cruise_speed        <= 8'd60;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ECHO_THRESHOLD: cfg.echo_threshold_us   <= cfg_data;
        REG_BACKUP_TICKS:   cfg.backup_ticks        <= cfg_data[7:0];
        REG_TURN_TICKS:     cfg.turn_ticks          <= cfg_data[7:0];
        REG_BLOCKED_EXTRA:  cfg.blocked_extra_ticks <= cfg_data[7:0];
        REG_STOP_TICKS:     cfg.stop_ticks          <= cfg_data[7:0];
        REG_PAUSE_TICKS:    cfg.pause_ticks         <= cfg_data[7:0];
        REG_SETTLE_TICKS:   cfg.settle_ticks        <= cfg_data[7:0];
        REG_CRUISE_SPEED:   cfg.cruise_speed        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/oas_step.sv =====
// ----------------------------------------------------------------------------
// oas_step
// Sequence state and the per-tick next state and motor command logic.
// ----------------------------------------------------------------------------
module oas_step
  import oas_pkg::*;
#(
  parameter int ECHO_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [15:0] echo_us,
  input  logic        timed_out,
  input  cfg_t        cfg,
  output result_t     result
);

  localparam int EW = (ECHO_BITS < 16) ? ECHO_BITS : 16;

  phase_t               phase, phase_next, run_phase;
  logic [TICK_BITS-1:0] tick_count, tick_count_next;
  logic [EW-1:0]        left_sample, left_sample_next;
  logic [EW-1:0]        centre_sample, centre_sample_next;
  logic                 turn_to_left, turn_to_left_next;

  logic [EW-1:0]        echo;
  logic [15:0]          echo_ext;
  logic [EW-1:0]        sample;
  logic                 detect;
  logic [TICK_BITS-1:0] tick_base, tick_inc, dur_raw, dur;
  logic                 done;
  logic [7:0]           cruise_clamped;

  assign echo     = echo_us[EW-1:0];
  assign echo_ext = 16'(echo);
  assign sample   = timed_out ? '0 : echo;
  assign detect   = !timed_out && (echo != '0) && (echo_ext < cfg.echo_threshold_us);
  assign cruise_clamped = (cfg.cruise_speed > SPEED_MAX) ? SPEED_MAX : cfg.cruise_speed;

  // a detection tick already counts as the first stop tick
  always_comb begin
    if (phase == PH_CRUISE) begin
      run_phase = detect ? PH_STOP : PH_CRUISE;
      tick_base = '0;
    end else begin
      run_phase = phase;
      tick_base = tick_count;
    end
  end

  always_comb begin
    case (run_phase)
      PH_STOP:           dur_raw = TICK_BITS'(cfg.stop_ticks);
      PH_BACKUP,
      PH_BLOCKED_BACKUP: dur_raw = TICK_BITS'(cfg.backup_ticks);
      PH_PAUSE,
      PH_FINAL_PAUSE:    dur_raw = TICK_BITS'(cfg.pause_ticks);
      PH_SCAN_LEFT,
      PH_SCAN_CENTRE,
      PH_SCAN_RIGHT:     dur_raw = TICK_BITS'(cfg.settle_ticks);
      PH_TURN:           dur_raw = TICK_BITS'(cfg.turn_ticks);
      PH_BLOCKED_TURN:   dur_raw = TICK_BITS'(cfg.turn_ticks)
                                   + TICK_BITS'(cfg.blocked_extra_ticks);
      default:           dur_raw = TICK_BITS'(cfg.pause_ticks);
    endcase
  end

  assign dur      = (dur_raw == '0) ? TICK_BITS'(1) : dur_raw;
  assign tick_inc = tick_base + TICK_BITS'(1);
  assign done     = (tick_inc >= dur);

  // next state
  always_comb begin
    phase_next         = run_phase;
    tick_count_next    = done ? '0 : tick_inc;
    left_sample_next   = left_sample;
    centre_sample_next = centre_sample;
    turn_to_left_next  = turn_to_left;
    case (run_phase)
      PH_CRUISE: begin
        tick_count_next = '0;
      end
      PH_STOP:           if (done) phase_next = PH_BACKUP;
      PH_BACKUP:         if (done) phase_next = PH_PAUSE;
      PH_PAUSE:          if (done) phase_next = PH_SCAN_LEFT;
      PH_SCAN_LEFT: begin
        if (done) begin
          phase_next       = PH_SCAN_CENTRE;
          left_sample_next = sample;
        end
      end
      PH_SCAN_CENTRE: begin
        if (done) begin
          phase_next         = PH_SCAN_RIGHT;
          centre_sample_next = sample;
        end
      end
      PH_SCAN_RIGHT: begin
        if (done) begin
          // ties go left only against right, never against centre
          if (left_sample >= sample && left_sample > centre_sample) begin
            turn_to_left_next = 1'b1;
            phase_next        = PH_TURN;
          end else if (sample > left_sample && sample > centre_sample) begin
            turn_to_left_next = 1'b0;
            phase_next        = PH_TURN;
          end else begin
            turn_to_left_next = 1'b0;
            phase_next        = PH_BLOCKED_BACKUP;
          end
        end
      end
      PH_TURN:           if (done) phase_next = PH_FINAL_PAUSE;
      PH_BLOCKED_BACKUP: if (done) phase_next = PH_BLOCKED_TURN;
      PH_BLOCKED_TURN:   if (done) phase_next = PH_FINAL_PAUSE;
      default:           if (done) phase_next = PH_CRUISE;
    endcase
  end

  // motor and servo command
  always_comb begin
    result.left_reverse   = 1'b0;
    result.left_speed     = '0;
    result.right_reverse  = 1'b0;
    result.right_speed    = '0;
    result.servo_position = SERVO_CENTRE;
    case (run_phase)
      PH_CRUISE: begin
        result.left_speed  = cruise_clamped;
        result.right_speed = cruise_clamped;
      end
      PH_BACKUP,
      PH_BLOCKED_BACKUP: begin
        result.left_reverse  = 1'b1;
        result.left_speed    = BACK_SPEED;
        result.right_reverse = 1'b1;
        result.right_speed   = BACK_SPEED;
      end
      PH_SCAN_LEFT:  result.servo_position = SERVO_POS_LEFT;
      PH_SCAN_RIGHT: result.servo_position = SERVO_POS_RIGHT;
      PH_TURN: begin
        if (turn_to_left) begin
          result.left_reverse = 1'b1;
          result.left_speed   = TURN_SLOW;
          result.right_speed  = TURN_FAST;
        end else begin
          result.left_speed    = TURN_FAST;
          result.right_reverse = 1'b1;
          result.right_speed   = TURN_SLOW;
        end
      end
      PH_BLOCKED_TURN: begin
        result.left_speed    = TURN_FAST;
        result.right_reverse = 1'b1;
        result.right_speed   = TURN_SLOW;
      end
      default: ;
    endcase
    result.phase_now = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CRUISE;
      tick_count    <= '0;
      left_sample   <= '0;
      centre_sample <= '0;
      turn_to_left  <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      left_sample   <= left_sample_next;
      centre_sample <= centre_sample_next;
      turn_to_left  <= turn_to_left_next;
    end
  end

endmodule

// ===== src/obstacle_avoid_sequencer.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer
// Tick-driven obstacle avoidance sequencer: motor and servo command per tick.
// ----------------------------------------------------------------------------
// One beat in is one 100 ms tick; each tick gives exactly one command beat out.
// A new tick is taken every clock cycle while no command is stalled; its
// command passes through the input register into the result register, with
// the sequence state updated as the tick leaves the input register. A stalled
// command holds the input register and then the input. Obstacle detection
// compares the echo width, masked to ECHO_BITS bits, with echo_threshold_us.
// Configuration is written through its own channel, which is always ready.
module obstacle_avoid_sequencer
  import oas_pkg::*;
#(
  parameter int ECHO_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             echo_us,
  input  logic                    timed_out,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    left_reverse,
  output logic [7:0]              left_speed,
  output logic                    right_reverse,
  output logic [7:0]              right_speed,
  output logic [1:0]              servo_position,
  output logic [3:0]              phase_now
);

  cfg_t        cfg;
  result_t     step_result, result;
  logic        s1_valid;
  logic [15:0] s1_echo;
  logic        s1_timed_out;
  logic        out_adv, s1_fire;

  assign out_adv  = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_adv;
  assign in_ready = !s1_valid || out_adv;

  oas_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  oas_step #(
    .ECHO_BITS (ECHO_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .echo_us   (s1_echo),
    .timed_out (s1_timed_out),
    .cfg       (cfg),
    .result    (step_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_echo      <= echo_us;
      s1_timed_out <= timed_out;
    end
  end

  // result register: hold while the beat is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= step_result;
    end
  end

  assign left_reverse   = result.left_reverse;
  assign left_speed     = result.left_speed;
  assign right_reverse  = result.right_reverse;
  assign right_speed    = result.right_speed;
  assign servo_position = result.servo_position;
  assign phase_now      = result.phase_now;

endmodule

// ===== src/oas_checker.sv =====
// ----------------------------------------------------------------------------
// oas_checker
// Port-level checks on the command beats of the sequencer.
// ----------------------------------------------------------------------------
module oas_checker
  import oas_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       left_reverse,
  input logic [7:0] left_speed,
  input logic       right_reverse,
  input logic [7:0] right_speed,
  input logic [1:0] servo_position,
  input logic [3:0] phase_now
);

  // no beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_speed) && $stable(right_speed)
      && $stable(servo_position) && $stable(phase_now))
    else $error("stalled result beat changed");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_speed <= SPEED_MAX && right_speed <= SPEED_MAX && phase_now <= 4'd10)
    else $error("speed or phase out of range");

  // reversing both motors only happens while backing up
  a_backup: assert property (@(posedge clk) disable iff (rst)
    out_valid && left_reverse && right_reverse |->
      left_speed == BACK_SPEED && right_speed == BACK_SPEED)
    else $error("both reverse without backup speed");

  // the servo leaves centre only during a scan, with the motors stopped
  a_scan_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && servo_position != SERVO_CENTRE |->
      left_speed == 8'd0 && right_speed == 8'd0 && servo_position != 2'd3)
    else $error("servo off centre while moving");

endmodule

bind obstacle_avoid_sequencer oas_checker u_oas_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .left_reverse   (left_reverse),
  .left_speed     (left_speed),
  .right_reverse  (right_reverse),
  .right_speed    (right_speed),
  .servo_position (servo_position),
  .phase_now      (phase_now)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the obstacle avoidance sequencer tick by tick: each accepted echo
// beat is run through a behavioral predictor of the phase sequence, and every
// command beat is compared field by field with the oldest prediction, under
// several register settings and with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import oas_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [15:0]              value;
    logic                     no_echo;
    logic                     has_want;
    result_t                  want;
  } stim_row_t;

  localparam result_t FWD_AT_RESET = {1'b0, 8'd60, 1'b0, 8'd60, SERVO_CENTRE, PH_CRUISE};
  localparam result_t FWD_CLAMPED  = {1'b0, 8'd150, 1'b0, 8'd150, SERVO_CENTRE, PH_CRUISE};

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0]             cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [15:0]             echo_us = '0;
  logic                    timed_out = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    left_reverse;
  logic [7:0]              left_speed;
  logic                    right_reverse;
  logic [7:0]              right_speed;
  logic [1:0]              servo_position;
  logic [3:0]              phase_now;

  obstacle_avoid_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .echo_us       (echo_us),
    .timed_out     (timed_out),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_reverse  (left_reverse),
    .left_speed    (left_speed),
    .right_reverse (right_reverse),
    .right_speed   (right_speed),
    .servo_position(servo_position),
    .phase_now     (phase_now)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor state and register copy
  cfg_t        regs_m;
  logic [3:0]  seq_phase;
  logic [8:0]  seq_ticks;
  logic [15:0] left_echo;
  logic [15:0] centre_echo;
  logic        turn_left;

  result_t     expected_cmds[$];
  stim_row_t   stim_rows[$];
  result_t     due_cmd;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          mismatches = 0;
  int          ticks_sent = 0;
  int          cmds_checked = 0;
  int          reg_writes = 0;
  int          stall_cycles = 0;
  logic [15:0] phases_seen = '0;

  function automatic result_t motor(input logic lrev, input logic [7:0] lspd,
                                    input logic rrev, input logic [7:0] rspd,
                                    input logic [1:0] servo);
    result_t r;
    r = '0;
    r.left_reverse   = lrev;
    r.left_speed     = lspd;
    r.right_reverse  = rrev;
    r.right_speed    = rspd;
    r.servo_position = servo;
    return r;
  endfunction

  function automatic result_t advance_sequence(input logic [15:0] smp);
    result_t    r;
    logic [8:0] dur;
    logic [3:0] nxt;
    case (seq_phase)
      PH_STOP: begin
        r = motor(1'b0, 8'd0, 1'b0, 8'd0, SERVO_CENTRE);
        dur = 9'(regs_m.stop_ticks); nxt = PH_BACKUP;
      end
      PH_BACKUP: begin
        r = motor(1'b1, BACK_SPEED, 1'b1, BACK_SPEED, SERVO_CENTRE);
        dur = 9'(regs_m.backup_ticks); nxt = PH_PAUSE;
      end
      PH_PAUSE: begin
        r = motor(1'b0, 8'd0, 1'b0, 8'd0, SERVO_CENTRE);
        dur = 9'(regs_m.pause_ticks); nxt = PH_SCAN_LEFT;
      end
      PH_SCAN_LEFT: begin
        r = motor(1'b0, 8'd0, 1'b0, 8'd0, SERVO_POS_LEFT);
        dur = 9'(regs_m.settle_ticks); nxt = PH_SCAN_CENTRE;
      end
      PH_SCAN_CENTRE: begin
        r = motor(1'b0, 8'd0, 1'b0, 8'd0, SERVO_CENTRE);
        dur = 9'(regs_m.settle_ticks); nxt = PH_SCAN_RIGHT;
      end
      PH_SCAN_RIGHT: begin
        r = motor(1'b0, 8'd0, 1'b0, 8'd0, SERVO_POS_RIGHT);
        dur = 9'(regs_m.settle_ticks); nxt = PH_TURN;
      end
      PH_TURN: begin
        if (turn_left) r = motor(1'b1, TURN_SLOW, 1'b0, TURN_FAST, SERVO_CENTRE);
        else r = motor(1'b0, TURN_FAST, 1'b1, TURN_SLOW, SERVO_CENTRE);
        dur = 9'(regs_m.turn_ticks); nxt = PH_FINAL_PAUSE;
      end
      PH_BLOCKED_BACKUP: begin
        r = motor(1'b1, BACK_SPEED, 1'b1, BACK_SPEED, SERVO_CENTRE);
        dur = 9'(regs_m.backup_ticks); nxt = PH_BLOCKED_TURN;
      end
      PH_BLOCKED_TURN: begin
        r = motor(1'b0, TURN_FAST, 1'b1, TURN_SLOW, SERVO_CENTRE);
        // 9-bit sum: the blocked turn can run up to 510 ticks
        dur = 9'(regs_m.turn_ticks) + 9'(regs_m.blocked_extra_ticks);
        nxt = PH_FINAL_PAUSE;
      end
      default: begin
        r = motor(1'b0, 8'd0, 1'b0, 8'd0, SERVO_CENTRE);
        dur = 9'(regs_m.pause_ticks); nxt = PH_CRUISE;
      end
    endcase
    if (dur == 0) dur = 9'd1;
    seq_ticks = seq_ticks + 9'd1;
    if (seq_ticks >= dur) begin
      seq_ticks = '0;
      case (seq_phase)
        PH_SCAN_LEFT:   left_echo = smp;
        PH_SCAN_CENTRE: centre_echo = smp;
        PH_SCAN_RIGHT: begin
          if (left_echo >= smp && left_echo > centre_echo) begin
            turn_left = 1'b1;
          end else if (smp > left_echo && smp > centre_echo) begin
            turn_left = 1'b0;
          end else begin
            turn_left = 1'b0;
            nxt = PH_BLOCKED_BACKUP;
          end
        end
        default: ;
      endcase
      seq_phase = nxt;
    end
    return r;
  endfunction

  function automatic result_t predict_command(input logic [15:0] echo, input logic no_echo);
    result_t    r;
    logic [7:0] cruise;
    cruise = (regs_m.cruise_speed > SPEED_MAX) ? SPEED_MAX : regs_m.cruise_speed;
    if (seq_phase == PH_CRUISE || seq_phase > PH_FINAL_PAUSE) begin
      seq_ticks = '0;
      if (!no_echo && echo != 0 && echo < regs_m.echo_threshold_us) begin
        seq_phase = PH_STOP;
        r = advance_sequence(echo);
      end else begin
        seq_phase = PH_CRUISE;
        r = motor(1'b0, cruise, 1'b0, cruise, SERVO_CENTRE);
      end
    end else begin
      r = advance_sequence(no_echo ? 16'd0 : echo);
    end
    r.phase_now = seq_phase;
    return r;
  endfunction

  task automatic send_tick(input logic [15:0] echo, input logic no_echo,
                           input logic has_want = 1'b0, input result_t want = '0);
    int      gap;
    result_t cmd;
    gap = 0;
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    echo_us   <= echo;
    timed_out <= no_echo;
    do @(posedge clk); while (!in_ready);
    cmd = predict_command(echo, no_echo);
    phases_seen[cmd.phase_now] = 1'b1;
    expected_cmds.push_back(has_want ? want : cmd);
    ticks_sent++;
  endtask

  // drop valid and let the pipeline drain before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] value);
    logic [15:0] data;
    data = value;
    // 8-bit registers must ignore the upper byte
    if (idx != REG_ECHO_THRESHOLD) data[15:8] = 8'($urandom_range(255));
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ECHO_THRESHOLD: regs_m.echo_threshold_us = data;
      REG_BACKUP_TICKS:   regs_m.backup_ticks = data[7:0];
      REG_TURN_TICKS:     regs_m.turn_ticks = data[7:0];
      REG_BLOCKED_EXTRA:  regs_m.blocked_extra_ticks = data[7:0];
      REG_STOP_TICKS:     regs_m.stop_ticks = data[7:0];
      REG_PAUSE_TICKS:    regs_m.pause_ticks = data[7:0];
      REG_SETTLE_TICKS:   regs_m.settle_ticks = data[7:0];
      REG_CRUISE_SPEED:   regs_m.cruise_speed = data[7:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] thr, input logic [7:0] backup,
                              input logic [7:0] turn, input logic [7:0] extra,
                              input logic [7:0] stop, input logic [7:0] pause,
                              input logic [7:0] settle, input logic [7:0] cruise);
    wait_idle();
    cfg_write(REG_ECHO_THRESHOLD, thr);
    cfg_write(REG_BACKUP_TICKS, {8'd0, backup});
    cfg_write(REG_TURN_TICKS, {8'd0, turn});
    cfg_write(REG_BLOCKED_EXTRA, {8'd0, extra});
    cfg_write(REG_STOP_TICKS, {8'd0, stop});
    cfg_write(REG_PAUSE_TICKS, {8'd0, pause});
    cfg_write(REG_SETTLE_TICKS, {8'd0, settle});
    cfg_write(REG_CRUISE_SPEED, {8'd0, cruise});
  endtask

  task automatic add_tick(input logic [15:0] echo, input logic no_echo,
                          input logic has_want = 1'b0, input result_t want = '0);
    stim_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.value = echo;
    row.no_echo = no_echo;
    row.has_want = has_want;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  task automatic add_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.value = value;
    stim_rows.push_back(row);
  endtask

  function automatic logic [7:0] short_ticks();
    return 8'($urandom_range(3));
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // receiver: random stalls, check each command beat
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: command beat arrived with nothing expected", $time);
      end else begin
        due_cmd = expected_cmds.pop_front();
        check_field("left_reverse", 16'(due_cmd.left_reverse), 16'(left_reverse));
        check_field("left_speed", 16'(due_cmd.left_speed), 16'(left_speed));
        check_field("right_reverse", 16'(due_cmd.right_reverse), 16'(right_reverse));
        check_field("right_speed", 16'(due_cmd.right_speed), 16'(right_speed));
        check_field("servo_position", 16'(due_cmd.servo_position), 16'(servo_position));
        check_field("phase_now", 16'(due_cmd.phase_now), 16'(phase_now));
        cmds_checked++;
      end
    end
  end

  // watchdog: count cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int          n;
    int          sel;
    logic [15:0] echo;
    logic        no_echo;

    regs_m      = {16'd1177, 8'd8, 8'd6, 8'd3, 8'd3, 8'd2, 8'd4, 8'd60};
    seq_phase   = PH_CRUISE;
    seq_ticks   = '0;
    left_echo   = '0;
    centre_echo = '0;
    turn_left   = 1'b0;

    // directed part: reset settings first, then one-tick phases
    add_tick(16'd0, 1'b0, 1'b1, FWD_AT_RESET);
    add_tick(16'd1000, 1'b1, 1'b1, FWD_AT_RESET);
    add_tick(16'd65535, 1'b0, 1'b1, FWD_AT_RESET);
    add_tick(16'd1177, 1'b0, 1'b1, FWD_AT_RESET);
    add_write(REG_STOP_TICKS, 16'd1);
    add_write(REG_BACKUP_TICKS, 16'd0);
    add_write(REG_PAUSE_TICKS, 16'd1);
    add_write(REG_SETTLE_TICKS, 16'd1);
    add_write(REG_TURN_TICKS, 16'd1);
    add_write(REG_BLOCKED_EXTRA, 16'd0);
    add_write(REG_CRUISE_SPEED, 16'd200);
    // left wins on a tie with right
    add_tick(16'd1176, 1'b0);
    add_tick(16'd1176, 1'b0);
    add_tick(16'd0, 1'b1);
    add_tick(16'd500, 1'b0);
    add_tick(16'd300, 1'b1);
    add_tick(16'd500, 1'b0);
    add_tick(16'd65535, 1'b0);
    add_tick(16'd1, 1'b0);
    add_tick(16'd0, 1'b0, 1'b1, FWD_CLAMPED);
    // all three samples equal: blocked
    add_tick(16'd1, 1'b0);
    add_tick(16'd2, 1'b0);
    add_tick(16'd3, 1'b0);
    add_tick(16'd100, 1'b0);
    add_tick(16'd100, 1'b0);
    add_tick(16'd100, 1'b0);
    add_tick(16'd0, 1'b0);
    add_tick(16'd0, 1'b1);
    add_tick(16'd0, 1'b0);
    // right clearest
    add_tick(16'd900, 1'b0);
    add_tick(16'd0, 1'b0);
    add_tick(16'd0, 1'b0);
    add_tick(16'd10, 1'b1);
    add_tick(16'd20, 1'b0);
    add_tick(16'd65535, 1'b0);
    add_tick(16'd0, 1'b0);
    add_tick(16'd0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(stim_rows[i].reg_idx, stim_rows[i].value);
      end else begin
        send_tick(stim_rows[i].value, stim_rows[i].no_echo, stim_rows[i].has_want,
                  stim_rows[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          snd_idle_pct = 0; rcv_stall_pct = 0; n = 200;
          program_regs(16'($urandom_range(3000, 500)), short_ticks(), short_ticks(),
                       short_ticks(), short_ticks(), short_ticks(), short_ticks(),
                       8'($urandom_range(255)));
        end
        1: begin
          snd_idle_pct = 84; rcv_stall_pct = 0; n = 150;
          program_regs(16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd150);
        end
        2: begin
          snd_idle_pct = 0; rcv_stall_pct = 84; n = 200;
          program_regs(16'($urandom_range(65535)), short_ticks(), short_ticks(),
                       short_ticks(), short_ticks(), short_ticks(), short_ticks(),
                       8'($urandom_range(255)));
        end
        3: begin
          // longest turns: blocked turn reaches 510 ticks
          snd_idle_pct = 11; rcv_stall_pct = 11; n = 500;
          program_regs(16'hFFFF, 8'd1, 8'd255, 8'd255, 8'd1, 8'd1, 8'd1, 8'd0);
        end
        4: begin
          snd_idle_pct = 0; rcv_stall_pct = 0; n = 300;
          program_regs(16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        end
        default: begin
          snd_idle_pct = 0; rcv_stall_pct = 84; n = 100;
          program_regs(16'd0, short_ticks(), short_ticks(), short_ticks(),
                       short_ticks(), short_ticks(), short_ticks(), 8'd0);
        end
      endcase
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(9);
        no_echo = ($urandom_range(9) == 0);
        case (sel)
          0: echo = 16'd0;
          1, 2: echo = (regs_m.echo_threshold_us > 1) ?
                       16'($urandom_range(regs_m.echo_threshold_us - 1, 1)) : 16'd1;
          3: echo = regs_m.echo_threshold_us;
          // few distinct values so scan samples tie often
          4, 5: echo = 16'(16'd100 * $urandom_range(3, 1));
          default: echo = 16'($urandom());
        endcase
        send_tick(echo, no_echo);
      end
    end

    snd_idle_pct = 0;
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Sent %0d ticks and %0d register writes; %0d commands checked",
             ticks_sent, reg_writes, cmds_checked);
    $display("Sequence phases reached, one bit per phase: %b", phases_seen[10:0]);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/oas_pkg.sv
src/oas_cfg_regs.sv
src/oas_step.sv
src/obstacle_avoid_sequencer.sv
src/oas_checker.sv
verif/testbench.sv
